@@ rtl/core/ecgdc_pkg.sv @@
// Shared constants, register codes and the low-pass coefficient ROM for the ECG filter.
package ecgdc_pkg;

  localparam int TAP_COUNT_DEF = 161;
  localparam int ROM_TAPS      = 161;

  localparam logic [15:0] POLE_RESET   = 16'd65012;
  localparam logic        INVERT_RESET = 1'b1;

  // Register codes, decoded from paddr[2]
  localparam logic REG_DC_POLE = 1'b0;
  localparam logic REG_INVERT  = 1'b1;

  localparam logic signed [15:0] LP_ROM [ROM_TAPS] = '{
    16'sd24, 16'sd38, 16'sd43, 16'sd38, 16'sd23, 16'sd0, -16'sd24, -16'sd46, -16'sd58, -16'sd57,
    -16'sd39, -16'sd8, 16'sd29, 16'sd66, 16'sd92, 16'sd96, 16'sd75, 16'sd29, -16'sd31, -16'sd94,
    -16'sd141, -16'sd157, -16'sd133, -16'sd68, 16'sd25, 16'sd127, 16'sd209, 16'sd247,
    16'sd224, 16'sd137, 16'sd0, -16'sd155, -16'sd291, -16'sd366, -16'sd354, -16'sd244,
    -16'sd55, 16'sd173, 16'sd385, 16'sd521, 16'sd535, 16'sd408, 16'sd157, -16'sd165,
    -16'sd484, -16'sd712, -16'sd778, -16'sd646, -16'sd326, 16'sd118, 16'sd585, 16'sd953,
    16'sd1112, 16'sd997, 16'sd603, 16'sd0, -16'sd677, -16'sd1261, -16'sd1585, -16'sd1529,
    -16'sd1059, -16'sd240, 16'sd758, 16'sd1702, 16'sd2334, 16'sd2437, 16'sd1900, 16'sd750,
    -16'sd819, -16'sd2483, -16'sd3824, -16'sd4418, -16'sd3922, -16'sd2153, 16'sd859,
    16'sd4856, 16'sd9374, 16'sd13820, 16'sd17568, 16'sd20070, 16'sd20948, 16'sd20070,
    16'sd17568, 16'sd13820, 16'sd9374, 16'sd4856, 16'sd859, -16'sd2153, -16'sd3922,
    -16'sd4418, -16'sd3824, -16'sd2483, -16'sd819, 16'sd750, 16'sd1900, 16'sd2437,
    16'sd2334, 16'sd1702, 16'sd758, -16'sd240, -16'sd1059, -16'sd1529, -16'sd1585,
    -16'sd1261, -16'sd677, 16'sd0, 16'sd603, 16'sd997, 16'sd1112, 16'sd953, 16'sd585,
    16'sd118, -16'sd326, -16'sd646, -16'sd778, -16'sd712, -16'sd484, -16'sd165, 16'sd157,
    16'sd408, 16'sd535, 16'sd521, 16'sd385, 16'sd173, -16'sd55, -16'sd244, -16'sd354,
    -16'sd366, -16'sd291, -16'sd155, 16'sd0, 16'sd137, 16'sd224, 16'sd247, 16'sd209,
    16'sd127, 16'sd25, -16'sd68, -16'sd133, -16'sd157, -16'sd141, -16'sd94, -16'sd31,
    16'sd29, 16'sd75, 16'sd96, 16'sd92, 16'sd66, 16'sd29, -16'sd8, -16'sd39, -16'sd57,
    -16'sd58, -16'sd46, -16'sd24, 16'sd0, 16'sd23, 16'sd38, 16'sd43, 16'sd38, 16'sd24
  };

  // Taps past the end of the ROM weigh zero
  function automatic logic signed [15:0] coef_at(input logic [7:0] idx);
    logic signed [15:0] c;
    c = 16'sd0;
    if (idx < 8'(ROM_TAPS)) c = LP_ROM[idx];
    return c;
  endfunction

endpackage

@@ rtl/core/ecgdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ecgdc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 161,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ecg_dc_block_fir_lowpass.sv @@
// ECG DC blocker followed by a TAP_COUNT-tap low-pass FIR on one shared multiplier.
//
// Input channel: raw_sample with in_valid/in_stall; a transaction happens when
// in_valid is high and in_stall is low. Output channel: filtered_sample and
// dc_removed_sample with out_valid/out_stall, one result per input.
// Each sample takes one multiply for the DC blocker pole, then one multiply per
// tap on the same 18x17 multiplier, reading the history RAM one entry a cycle.
// The result passes the pole multiply, the history write, the tap walk and the
// drain of the tap pipeline before the finish step; a new sample is taken only after
// that step, set by the tap walk through the single multiplier and history RAM port.
// in_stall stays high while a sample is in work.
// The result sits in an output register; the block takes the next sample while
// it waits, and holds at the end of that next sample until out_stall drops.
// Reset (rst, synchronous) clears the DC blocker state, the history fill count
// and write pointer, and sets dc_pole to 65012 and invert_output to 1. History
// entries not yet written since reset read as zero through the fill count.
// APB registers: dc_pole at 0x0, invert_output at 0x4; pready is always high.
module ecg_dc_block_fir_lowpass import ecgdc_pkg::*; #(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] filtered_sample,
  output logic signed [13:0] dc_removed_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int FIL_W = $clog2(TAP_COUNT + 1);
  localparam int ACC_W = 40;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POLE   = 3'd1;
  localparam logic [2:0] S_DCY    = 3'd2;
  localparam logic [2:0] S_TAP    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]  state, state_next;
  logic [15:0] dc_pole;
  logic        invert_output;

  logic signed [15:0] x_reg, prev_raw, prev_y;
  logic [IDX_W-1:0]   wr_idx, rd_idx, tap_cnt, tap1;
  logic [FIL_W-1:0]   fill;
  logic               v1, v2;
  logic signed [34:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] mul_out;
  logic [16:0]        prev_mag;
  logic signed [16:0] scaled;
  logic signed [18:0] y_wide;
  logic signed [15:0] y_sat;
  logic [13:0]        ram_q;
  logic               ram_we;
  logic               tap_ok;
  logic signed [31:0] sum_sat, result;
  logic               load_out, in_take;
  logic               cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_pole       <= POLE_RESET;
      invert_output <= INVERT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DC_POLE: dc_pole       <= pwdata[15:0];
        REG_INVERT:  invert_output <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DC_POLE: prdata = {16'd0, dc_pole};
      REG_INVERT:  prdata = {31'd0, invert_output};
      default:     prdata = 32'd0;
    endcase
  end

  // Shared multiplier: pole product first, then one tap per cycle
  assign prev_mag = prev_y[15] ? 17'(-17'(prev_y)) : 17'(prev_y);
  assign tap_ok   = FIL_W'(tap1) < fill;

  always_comb begin
    if (state == S_POLE) begin
      mul_a = $signed({1'b0, prev_mag});
      mul_b = $signed({1'b0, dc_pole});
    end else begin
      mul_a = 18'(coef_at(8'(tap1)));
      mul_b = tap_ok ? 17'($signed(ram_q)) : 17'sd0;
    end
  end

  assign mul_out = mul_a * mul_b;

  // DC blocker: truncate the pole product toward zero, then saturate
  assign scaled = prev_y[15] ? -$signed({1'b0, prod[31:16]}) : $signed({1'b0, prod[31:16]});
  assign y_wide = 19'(x_reg) - 19'(prev_raw) + 19'(scaled);

  always_comb begin
    if (y_wide > 19'sd32767)       y_sat = 16'sh7fff;
    else if (y_wide < -19'sd32768) y_sat = 16'sh8000;
    else                           y_sat = y_wide[15:0];
  end

  assign ram_we = (state == S_DCY);

  ecgdc_ram #(
    .WIDTH (14),
    .DEPTH (TAP_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (y_sat[15:2]),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Saturate the sum to 32 bits, then, when invert_output is set, negate with saturation
  always_comb begin
    if (acc > ACC_W'(64'sd2147483647))       sum_sat = 32'sh7fffffff;
    else if (acc < ACC_W'(-64'sd2147483648)) sum_sat = 32'sh80000000;
    else                                     sum_sat = acc[31:0];
    if (!invert_output)               result = sum_sat;
    else if (sum_sat == 32'sh80000000) result = 32'sh7fffffff;
    else                              result = -sum_sat;
  end

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign load_out = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_take) state_next = S_POLE;
      S_POLE:   state_next = S_DCY;
      S_DCY:    state_next = S_TAP;
      S_TAP:    if (tap_cnt == IDX_W'(TAP_COUNT - 1)) state_next = S_DRAIN;
      S_DRAIN:  if (!v1 && !v2) state_next = S_FINISH;
      S_FINISH: if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prev_raw <= 16'sd0;
      prev_y   <= 16'sd0;
      wr_idx   <= '0;
      fill     <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == S_TAP);
      v2    <= v1;
      if (state == S_DCY) begin
        prev_raw <= x_reg;
        prev_y   <= y_sat;
        wr_idx   <= (wr_idx == IDX_W'(TAP_COUNT - 1)) ? '0 : wr_idx + 1'b1;
        if (fill != FIL_W'(TAP_COUNT)) fill <= fill + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_take) x_reg <= raw_sample;
    if (state == S_POLE || v1) prod <= mul_out;
    tap1 <= tap_cnt;
    if (state == S_DCY) begin
      rd_idx  <= wr_idx;
      tap_cnt <= '0;
      acc     <= '0;
    end else begin
      if (state == S_TAP) begin
        // walk back from the newest sample
        rd_idx  <= (rd_idx == '0) ? IDX_W'(TAP_COUNT - 1) : rd_idx - 1'b1;
        tap_cnt <= tap_cnt + 1'b1;
      end
      if (v2) acc <= acc + ACC_W'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_sample   <= result;
      dc_removed_sample <= prev_y[15:2];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FIL_W'(TAP_COUNT))
    else $error("history fill count exceeds tap count");

  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= IDX_W'(TAP_COUNT - 1))
    else $error("history write pointer out of range");

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !v1 && !v2)
    else $error("tap pipeline busy while idle");

  a_take_pole: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_POLE)
    else $error("input transaction did not start the pole multiply");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result presented outside the finish step");
`endif

endmodule
